FILE: hw/rtl/assert_macros.svh
// Concurrent assertion helpers, sampled on the rising clock edge and
// disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/bdpc_pkg.sv
package bdpc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int COUNT_W    = 8;

    localparam logic [COUNT_W-1:0] SETTLE_RESET  = 8'd10;
    localparam logic [COUNT_W-1:0] TWO_RESET     = 8'd2;
    localparam logic [COUNT_W-1:0] LONG_RESET    = 8'd3;
    localparam logic [COUNT_W-1:0] EXTLONG_RESET = 8'd6;
    localparam logic [COUNT_W-1:0] HELD_MAX      = 8'hFF;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [2:0] {
        EV_DOWN    = 3'd0,
        EV_UP      = 3'd1,
        EV_SHORT   = 3'd2,
        EV_TWO     = 3'd3,
        EV_LONG    = 3'd4,
        EV_EXTLONG = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        ST_INIT     = 3'b001,
        ST_RELEASED = 3'b010,
        ST_PRESSED  = 3'b100
    } press_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETTLE  = 2'd0,
        CFG_TWO     = 2'd1,
        CFG_LONG    = 2'd2,
        CFG_EXTLONG = 2'd3
    } cfg_index_t;

    // One queue entry: one or two events from a single input beat.
    typedef struct packed {
        logic   pair;
        event_t ev0;
        event_t ev1;
    } packet_t;

endpackage

FILE: hw/rtl/bdpc_front.sv
module bdpc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic                            pin_level,
    input  logic                            cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            q_full,
    output logic                            push,
    output bdpc_pkg::packet_t               push_pkt
);
    import bdpc_pkg::*;

    logic [COUNT_W-1:0] settle_polls_reg;
    logic [COUNT_W-1:0] two_count_reg;
    logic [COUNT_W-1:0] long_count_reg;
    logic [COUNT_W-1:0] extlong_count_reg;

    press_state_t       state_reg, state_next;
    logic               stable_reg, stable_next;
    logic [COUNT_W-1:0] settle_reg, settle_next;
    logic [COUNT_W-1:0] held_reg, held_next;

    logic               accept;
    logic [COUNT_W-1:0] held_inc;
    logic               hit_two;
    logic               hit_long;
    logic               hit_ext;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign held_inc = held_reg + 1'b1;
    assign hit_two  = (held_inc == two_count_reg);
    assign hit_long = (held_inc == long_count_reg);
    assign hit_ext  = !hit_long && (held_inc == extlong_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_polls_reg  <= SETTLE_RESET;
            two_count_reg     <= TWO_RESET;
            long_count_reg    <= LONG_RESET;
            extlong_count_reg <= EXTLONG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SETTLE:  settle_polls_reg  <= cfg_data;
                CFG_TWO:     two_count_reg     <= cfg_data;
                CFG_LONG:    long_count_reg    <= cfg_data;
                CFG_EXTLONG: extlong_count_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        stable_next = stable_reg;
        settle_next = settle_reg;
        held_next   = held_reg;
        push        = 1'b0;
        push_pkt    = '{pair: 1'b0, ev0: EV_DOWN, ev1: EV_DOWN};
        if (accept)
        begin
            if (mode)
            begin
                if (state_reg == ST_PRESSED && held_reg != HELD_MAX)
                begin
                    held_next     = held_inc;
                    push          = hit_two || hit_long || hit_ext;
                    push_pkt.pair = hit_two && (hit_long || hit_ext);
                    push_pkt.ev0  = hit_two ? EV_TWO : (hit_long ? EV_LONG : EV_EXTLONG);
                    push_pkt.ev1  = hit_long ? EV_LONG : EV_EXTLONG;
                end
            end
            else
            begin
                if (pin_level == stable_reg)
                begin
                    if (settle_reg != '0)
                    begin
                        settle_next = settle_reg - 1'b1;
                    end
                end
                else
                begin
                    settle_next = settle_polls_reg;
                    stable_next = pin_level;
                end
                if (settle_next == '0)
                begin
                    unique case (state_reg)
                        ST_PRESSED:
                        begin
                            if (stable_next)
                            begin
                                push          = 1'b1;
                                push_pkt.ev0  = EV_UP;
                                push_pkt.ev1  = EV_SHORT;
                                push_pkt.pair = (held_reg < two_count_reg);
                                state_next    = ST_RELEASED;
                            end
                        end
                        ST_RELEASED:
                        begin
                            if (!stable_next)
                            begin
                                push         = 1'b1;
                                push_pkt.ev0 = EV_DOWN;
                                held_next    = '0;
                                state_next   = ST_PRESSED;
                            end
                        end
                        default:
                        begin
                            if (stable_next)
                            begin
                                state_next = ST_RELEASED;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            stable_reg <= 1'b1;
            settle_reg <= '0;
            held_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            stable_reg <= stable_next;
            settle_reg <= settle_next;
            held_reg   <= held_next;
        end
    end

endmodule

FILE: hw/rtl/bdpc_queue.sv
`include "assert_macros.svh"

module bdpc_queue #(
    parameter int DEPTH = bdpc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bdpc_pkg::packet_t push_pkt,
    output logic              full,
    input  logic              pop,
    output bdpc_pkg::packet_t pop_pkt,
    output logic              empty
);
    import bdpc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    packet_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign pop_pkt = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !empty)
    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CNT_FULL)

endmodule

FILE: hw/rtl/bdpc_back.sv
`include "assert_macros.svh"

module bdpc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  bdpc_pkg::packet_t q_pkt,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        event_res,
    output logic              last
);
    import bdpc_pkg::*;

    logic    hold_valid_reg, hold_valid_next;
    logic    phase_reg, phase_next;
    packet_t pkt_reg;

    logic    beat_done;
    logic    finish;

    assign out_valid = hold_valid_reg;
    assign event_res = phase_reg ? pkt_reg.ev1 : pkt_reg.ev0;
    assign last      = !pkt_reg.pair || phase_reg;

    assign beat_done = hold_valid_reg && out_ready;
    assign finish    = beat_done && last;
    assign pop       = !q_empty && (!hold_valid_reg || finish);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        phase_next      = phase_reg;
        if (pop)
        begin
            hold_valid_next = 1'b1;
            phase_next      = 1'b0;
        end
        else if (finish)
        begin
            hold_valid_next = 1'b0;
            phase_next      = 1'b0;
        end
        else if (beat_done)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pkt_reg <= q_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
        end
    end

    // second beat only exists for a held two-event packet
    `ASSERT_IMPLIES(a_phase_pair, clk, rst_n, phase_reg, hold_valid_reg && pkt_reg.pair)

endmodule

FILE: hw/rtl/button_debounce_press_classifier_core.sv
// Debounce and press classifier for one active-low push button. One input
// beat (pin poll or one-second tick) is taken every clock cycle while the
// event queue has room; each beat is settled in that same cycle and yields
// zero, one or two event beats, queued as one entry. Event beats leave from
// a registered output stage at one per cycle while out_ready is high, so a
// two-event beat holds it for both events and the queue (QUEUE_DEPTH entries)
// absorbs that and any output stall. The last flag marks the final event of
// an input beat. Configuration is written through cfg_we/cfg_index/cfg_data
// with no wait state and should only be written while no events are pending.
module button_debounce_press_classifier_core #(
    parameter int QUEUE_DEPTH = bdpc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic                            pin_level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      event_res,
    output logic                            last,
    input  logic                            cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bdpc_pkg::*;

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    packet_t push_pkt;
    packet_t pop_pkt;

    bdpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .pin_level (pin_level),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_pkt  (push_pkt)
    );

    bdpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .full     (q_full),
        .pop      (pop),
        .pop_pkt  (pop_pkt),
        .empty    (q_empty)
    );

    bdpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pkt     (pop_pkt),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .event_res (event_res),
        .last      (last)
    );

endmodule
